// ===== rtl/core/write_watch_slot_table_core_defines.svh =====
// assertion macros for the write-watch slot table
`ifndef WRITE_WATCH_SLOT_TABLE_CORE_DEFINES_SVH
`define WRITE_WATCH_SLOT_TABLE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define WWST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define WWST_ASSERT_KNOWN(label, clk, rst_n, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
    else $error("unknown value");
`else
`define WWST_ASSERT(label, clk, rst_n, prop)
`define WWST_ASSERT_KNOWN(label, clk, rst_n, sig)
`endif
`endif

// ===== rtl/core/wwst_pkg.sv =====
`default_nettype none
package wwst_pkg;

  localparam int unsigned NumSlotsDef = 4;
  localparam int unsigned LogDepthDef = 8;
  localparam int unsigned CntW        = 21;
  localparam logic [CntW-1:0] CntMax  = {CntW{1'b1}};
  localparam logic [31:0] PtrThrRst   = 32'hC000_0000;
  localparam logic [CntW-1:0] TrapRst = 21'h10_0000;

  // register indexes
  localparam logic [1:0] RegPtrThr  = 2'd0;
  localparam logic [1:0] RegTrap    = 2'd1;
  localparam logic [1:0] RegStopPtr = 2'd2;

  // item modes
  localparam logic [2:0] ModeStore   = 3'd0;
  localparam logic [2:0] ModeArm     = 3'd1;
  localparam logic [2:0] ModeRoll    = 3'd2;
  localparam logic [2:0] ModeDisarm  = 3'd3;
  localparam logic [2:0] ModeDisAll  = 3'd4;
  localparam logic [2:0] ModeReadLog = 3'd5;

  // result status
  localparam logic [2:0] StDone    = 3'd0;
  localparam logic [2:0] StWatched = 3'd1;
  localparam logic [2:0] StNoSlot  = 3'd2;
  localparam logic [2:0] StNoMatch = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] address;
    logic [31:0] value;
    logic [31:0] pc;
    logic [31:0] lr;
    logic [2:0]  cpu;
    logic [14:0] pid;
    logic        irq_ctx;
    logic        flag;
    logic [1:0]  slot_index;
    logic        pointer_log;
    logic [2:0]  log_index;
  } item_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [1:0]      slot;
    logic [CntW-1:0] hits;
    logic [CntW-1:0] pointer_hits;
    logic            slot_armed;
    logic [29:0]     slot_word;
    logic [31:0]     log_value;
    logic [31:0]     log_pc;
    logic [31:0]     log_lr;
    logic [2:0]      log_cpu;
    logic [14:0]     log_pid;
    logic            log_irq;
  } item_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/wwst_front.sv =====
`default_nettype none
// front: accepts items into a two-entry queue and hands them to the back
module wwst_front import wwst_pkg::*; (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire item_in_t item_i,
  output logic          busy_o,
  output logic          q_valid_o,
  output item_in_t      q_item_o,
  input  wire           q_pop_i
);

  item_in_t  mem_q [2];
  logic      wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i && q_valid_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i && q_valid_o) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule
`default_nettype wire

// ===== rtl/core/wwst_back.sv =====
`default_nettype none
`include "write_watch_slot_table_core_defines.svh"
// back: slot match, counting, logging and readout
module wwst_back import wwst_pkg::*; #(
  parameter int unsigned NumSlots = NumSlotsDef,
  parameter int unsigned LogDepth = LogDepthDef
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       q_valid_i,
  input  wire item_in_t q_item_i,
  output logic      q_pop_o,
  input  wire [31:0] ptr_thr_i,
  input  wire [CntW-1:0] trap_i,
  input  wire       stop_ptr_i,
  output logic      done_o,
  output item_out_t result_o
);

  localparam int unsigned SW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned LW = (LogDepth > 1) ? $clog2(LogDepth) : 1;
  localparam int unsigned Entries = NumSlots * 2 * LogDepth;
  localparam int unsigned AW = $clog2(Entries);
  localparam int unsigned TagW = 19;

  logic [29:0]     word_q   [NumSlots];
  logic [NumSlots-1:0] act_q, sticky_q;
  logic [CntW-1:0] cnt_q    [NumSlots];
  logic [CntW-1:0] pcnt_q   [NumSlots];

  logic [31:0]     ev_mem [Entries];
  logic [31:0]     epc_mem [Entries];
  logic [31:0]     elr_mem [Entries];
  logic [TagW-1:0] etag_mem [Entries];

  // stage 1 regs (read pending) and output regs
  logic            rd_pend_q;
  item_out_t       hold_q, res_q, res_d;
  logic            done_q;
  logic [31:0]     rv_q, rpc_q, rlr_q;
  logic [TagW-1:0] rtag_q;

  item_in_t it;
  logic [29:0] word;
  logic        hit_any, free_any, roll_any;
  logic [SW-1:0] hit_s, free_s, roll_s, tgt, sel;
  logic          sidx_ok;
  logic [CntW-1:0] n, p;
  logic          is_ptr;
  logic          wr0, wr1;
  logic [AW-1:0] a0, a1, ra;
  logic [CntW-1:0] rcnt;
  logic          rd_ok;
  item_out_t     r;

  assign it   = q_item_i;
  assign word = it.address[31:2];
  // one item at a time: no pop while the previous item's update and log read finish
  assign q_pop_o = q_valid_i && !rd_pend_q;

  // slot search, lowest first
  always_comb begin
    hit_any = 1'b0; free_any = 1'b0; roll_any = 1'b0;
    hit_s = '0; free_s = '0; roll_s = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (act_q[i] && word_q[i] == word) begin hit_any = 1'b1; hit_s = SW'(i); end
      if (!act_q[i]) begin free_any = 1'b1; free_s = SW'(i); end
      if (act_q[i] && !sticky_q[i]) begin roll_any = 1'b1; roll_s = SW'(i); end
    end
  end

  assign sidx_ok = ({1'b0, it.slot_index} < 3'(NumSlots)) || (NumSlots >= 4);
  assign sel     = SW'(it.slot_index);
  assign n       = (cnt_q[hit_s] < CntMax) ? cnt_q[hit_s] + 1'b1 : CntMax;
  assign p       = (pcnt_q[hit_s] < CntMax) ? pcnt_q[hit_s] + 1'b1 : CntMax;
  assign is_ptr  = it.value >= ptr_thr_i;
  assign wr0 = q_pop_o && it.mode == ModeStore && hit_any && n <= CntW'(LogDepth);
  assign wr1 = q_pop_o && it.mode == ModeStore && hit_any && is_ptr
               && p <= CntW'(LogDepth);
  assign a0  = AW'(({hit_s, 1'b0} * LogDepth) + LW'(n - 1'b1));
  assign a1  = AW'(({hit_s, 1'b1} * LogDepth) + LW'(p - 1'b1));
  assign ra  = AW'(({sel, it.pointer_log} * LogDepth) + LW'(it.log_index));
  assign rcnt = it.pointer_log ? pcnt_q[sel] : cnt_q[sel];
  assign rd_ok = (32'(it.log_index) < LogDepth) && (CntW'(it.log_index) < rcnt);

  // slot state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0; sticky_q <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        word_q[i] <= '0; cnt_q[i] <= '0; pcnt_q[i] <= '0;
      end
    end else if (q_pop_o) begin
      case (it.mode)
        ModeStore: begin
          if (hit_any) begin
            cnt_q[hit_s] <= n;
            if (is_ptr) pcnt_q[hit_s] <= p;
            if ((is_ptr && stop_ptr_i) || n >= trap_i) act_q[hit_s] <= 1'b0;
          end
        end
        ModeArm, ModeRoll: begin
          if (!(it.mode == ModeRoll && word == '0) && !hit_any &&
              (free_any || (it.mode == ModeRoll && (roll_any || it.flag)))) begin
            word_q[tgt] <= word; cnt_q[tgt] <= '0; pcnt_q[tgt] <= '0;
            act_q[tgt] <= 1'b1;
            sticky_q[tgt] <= (it.mode == ModeArm) ? it.flag : 1'b0;
          end
        end
        ModeDisarm: if (sidx_ok) act_q[sel] <= 1'b0;
        ModeDisAll: act_q <= '0;
        default: ;
      endcase
    end
  end

  assign tgt = free_any ? free_s : (roll_any ? roll_s : '0);

  // log memory: up to two writes per store item, one registered read
  always_ff @(posedge clk_i) begin
    if (wr0) begin
      ev_mem[a0] <= it.value; epc_mem[a0] <= it.pc; elr_mem[a0] <= it.lr;
      etag_mem[a0] <= {it.irq_ctx, it.pid, it.cpu};
    end
    if (wr1) begin
      ev_mem[a1] <= it.value; epc_mem[a1] <= it.pc; elr_mem[a1] <= it.lr;
      etag_mem[a1] <= {it.irq_ctx, it.pid, it.cpu};
    end
    rv_q <= ev_mem[ra]; rpc_q <= epc_mem[ra];
    rlr_q <= elr_mem[ra]; rtag_q <= etag_mem[ra];
  end

  // result from current state
  always_comb begin
    logic [SW-1:0] s;
    logic          put;
    r = '0;
    r.status = StNoMatch;
    s = '0;
    put = 1'b0;
    case (it.mode)
      ModeStore: if (hit_any) begin
        r.status = StDone; s = hit_s; put = 1'b1;
      end
      ModeArm, ModeRoll: begin
        if (it.mode == ModeRoll && word == '0) r.status = StNoMatch;
        else if (hit_any) begin r.status = StWatched; s = hit_s; put = 1'b1; end
        else if (free_any || (it.mode == ModeRoll && (roll_any || it.flag))) begin
          r.status = StDone; s = tgt; put = 1'b1;
        end else r.status = StNoSlot;
      end
      ModeDisarm: if (sidx_ok) begin
        r.status = act_q[sel] ? StDone : StNoMatch; s = sel; put = 1'b1;
      end
      ModeDisAll: r.status = StDone;
      ModeReadLog: if (sidx_ok) begin
        r.status = rd_ok ? StDone : StEmpty; s = sel; put = 1'b1;
      end
      default: ;
    endcase
    if (put) r.slot = 2'(s);
    r.hits = '0; // filled after update
    r.slot_armed = 1'b0;
  end

  // hold the result until state after the item is visible
  logic pend_q, pend_put_q, pend_rd_q;
  logic [SW-1:0] pend_s_q;
  logic put_c;
  assign put_c = (r.status != StNoSlot) && !(r.status == StNoMatch &&
                 !(it.mode == ModeDisarm && sidx_ok));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0; rd_pend_q <= 1'b0;
    end else begin
      pend_q    <= q_pop_o;
      rd_pend_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      hold_q     <= r;
      pend_s_q   <= SW'(r.slot);
      pend_put_q <= put_c && it.mode != ModeDisAll;
      pend_rd_q  <= it.mode == ModeReadLog && sidx_ok && rd_ok;
    end
  end

  // merge slot state and log read into the held result
  always_comb begin
    res_d = hold_q;
    if (pend_put_q) begin
      res_d.hits         = cnt_q[pend_s_q];
      res_d.pointer_hits = pcnt_q[pend_s_q];
      res_d.slot_armed   = act_q[pend_s_q];
      res_d.slot_word    = word_q[pend_s_q];
    end
    if (pend_rd_q) begin
      res_d.log_value = rv_q; res_d.log_pc = rpc_q; res_d.log_lr = rlr_q;
      res_d.log_cpu = rtag_q[2:0]; res_d.log_pid = rtag_q[17:3];
      res_d.log_irq = rtag_q[18];
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= pend_q;
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `WWST_ASSERT(a_pop_gap, clk_i, rst_ni, q_pop_o |=> !q_pop_o)
  `WWST_ASSERT(a_done_follows, clk_i, rst_ni, q_pop_o |=> ##1 done_o)
  `WWST_ASSERT(a_disall_clear, clk_i, rst_ni, (q_pop_o && it.mode == ModeDisAll) |=> act_q == '0)
  `WWST_ASSERT_KNOWN(a_done_known, clk_i, rst_ni, done_o)

endmodule
`default_nettype wire

// ===== rtl/core/write_watch_slot_table_core.sv =====
`default_nettype none
// Write-watch slot table. Items enter through start_i/busy_o into a two-entry
// queue; the back end takes no new item while the previous one is pending
// (slot update, then readout of the updated slot and the registered log
// memory read). With the queue empty, an accepted item passes the queue
// entry, the pend/hold registers and the done_o/result_o output registers.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Log memories hold no reset; configuration is written with cfg_we_i.
module write_watch_slot_table_core import wwst_pkg::*; #(
  parameter int unsigned NumSlots = NumSlotsDef,
  parameter int unsigned LogDepth = LogDepthDef
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  output logic          busy_o,
  input  wire item_in_t item_i,
  output logic          done_o,
  output item_out_t     result_o,
  input  wire           cfg_we_i,
  input  wire [1:0]     cfg_idx_i,
  input  wire [31:0]    cfg_data_i
);

  logic [31:0]     ptr_thr_q;
  logic [CntW-1:0] trap_q;
  logic            stop_q;
  logic            q_valid, q_pop;
  item_in_t        q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_thr_q <= PtrThrRst; trap_q <= TrapRst; stop_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPtrThr:  ptr_thr_q <= cfg_data_i;
        RegTrap:    trap_q <= cfg_data_i[CntW-1:0];
        RegStopPtr: stop_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wwst_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  wwst_back #(.NumSlots(NumSlots), .LogDepth(LogDepth)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .ptr_thr_i(ptr_thr_q), .trap_i(trap_q), .stop_ptr_i(stop_q),
    .done_o, .result_o
  );

endmodule
`default_nettype wire
